/* rtl/vrp_pkg.sv */
`default_nettype none

package vrp_pkg;

	// screen size in pixels
	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 240;
	localparam int SCREEN_MAX    = 4096;
	localparam int SIZE_W        = $clog2(SCREEN_MAX + 1);

	// datapath widths
	localparam int NUM_W   = 40;               // projected numerators, Q.24
	localparam int DIV_W   = 24;               // magnitude of w
	localparam int RND_W   = NUM_W - 12 + 1;   // numerator rounded to Q.12
	localparam int CLAMP_W = 31;               // screen input before mapping
	localparam int PROD_W  = 46;               // screen mapping product
	localparam int OUT_W   = 24;
	localparam int LANES   = 3;

	// register map
	localparam int NUM_REGS = 8;
	localparam int ADDR_W   = $clog2(NUM_REGS) + 2;

	typedef enum logic [$clog2(NUM_REGS)-1:0] {
		REG_COS_Z,
		REG_SIN_Z,
		REG_COS_X,
		REG_SIN_X,
		REG_PROJ_X,
		REG_PROJ_Y,
		REG_DEPTH_SCALE,
		REG_DEPTH_OFFSET
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [15:0] vertex_z;
	} vertex_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] screen_x;
		logic signed [OUT_W-1:0] screen_y;
		logic signed [OUT_W-1:0] depth;
		logic                    w_zero;
	} result_t;

	typedef struct packed {
		logic signed [15:0] cos_z_rot;
		logic signed [15:0] sin_z_rot;
		logic signed [15:0] cos_x_rot;
		logic signed [15:0] sin_x_rot;
		logic        [15:0] proj_x_scale;
		logic        [15:0] proj_y_scale;
		logic        [15:0] depth_scale;
		logic signed [15:0] depth_offset;
	} cfg_t;

	// item handed from the front to the divider
	typedef struct packed {
		logic signed [NUM_W-1:0] nx;
		logic signed [NUM_W-1:0] ny;
		logic signed [NUM_W-1:0] nz;
		logic signed [DIV_W-1:0] w;
	} proj_t;

	// saturate to the signed output range
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
		lo = PROD_W'(-(64'sd1 <<< (OUT_W - 1)));
		if (v > hi) begin
			return OUT_W'(hi);
		end else if (v < lo) begin
			return OUT_W'(lo);
		end
		return OUT_W'(v);
	endfunction

endpackage

`default_nettype wire

/* rtl/vertex_rotate_project_core.sv */
// Vertex rotate and project core.
// Items come in on the vertex port (push/full): one model vertex, Q4.12.
// Each is rotated about Z then X, pushed 3.0 into the screen, projected,
// divided by w and mapped to pixels. Results leave on the result port
// (empty/pop): screen x/y in Q16.8, depth in Q12.12, and a w_zero flag
// set when w was zero and the rounded numerators are given instead.
// One item is accepted per cycle while full is low, and one result leaves
// per cycle while the receiver keeps popping. An item passes through 5 front
// stages (rotation and projection products), the 4-entry queue, the divider
// entry and 40 stages of a pipelined restoring divider (one quotient bit
// each), then 3 stages of mapping, before its result can be popped.
// A stalled receiver holds the divider pipe; the front keeps accepting
// until the queue fills, then raises full.
// Reset empties the pipe and loads the default rotation and projection
// registers. The registers sit on an APB port at byte address 4*index
// and should be written only while no item is in flight.
`default_nettype none

module vertex_rotate_project_core import vrp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire vertex_t           vertex,
	output logic                   full,
	input  wire logic              pop,
	output logic                   empty,
	output result_t                result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     q_push, q_full, q_pop, q_valid;
	proj_t    q_wdata, q_rdata;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_z_rot    <= 16'sd16384;
			cfg_q.sin_z_rot    <= '0;
			cfg_q.cos_x_rot    <= 16'sd16384;
			cfg_q.sin_x_rot    <= '0;
			cfg_q.proj_x_scale <= 16'd3840;
			cfg_q.proj_y_scale <= 16'd4096;
			cfg_q.depth_scale  <= 16'd4096;
			cfg_q.depth_offset <= -16'sd410;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_COS_Z:        cfg_q.cos_z_rot    <= pwdata[15:0];
				REG_SIN_Z:        cfg_q.sin_z_rot    <= pwdata[15:0];
				REG_COS_X:        cfg_q.cos_x_rot    <= pwdata[15:0];
				REG_SIN_X:        cfg_q.sin_x_rot    <= pwdata[15:0];
				REG_PROJ_X:       cfg_q.proj_x_scale <= pwdata[15:0];
				REG_PROJ_Y:       cfg_q.proj_y_scale <= pwdata[15:0];
				REG_DEPTH_SCALE:  cfg_q.depth_scale  <= pwdata[15:0];
				REG_DEPTH_OFFSET: cfg_q.depth_offset <= pwdata[15:0];
				default:          ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (idx)
			REG_COS_Z:        prdata = {16'b0, cfg_q.cos_z_rot};
			REG_SIN_Z:        prdata = {16'b0, cfg_q.sin_z_rot};
			REG_COS_X:        prdata = {16'b0, cfg_q.cos_x_rot};
			REG_SIN_X:        prdata = {16'b0, cfg_q.sin_x_rot};
			REG_PROJ_X:       prdata = {16'b0, cfg_q.proj_x_scale};
			REG_PROJ_Y:       prdata = {16'b0, cfg_q.proj_y_scale};
			REG_DEPTH_SCALE:  prdata = {16'b0, cfg_q.depth_scale};
			REG_DEPTH_OFFSET: prdata = {16'b0, cfg_q.depth_offset};
			default:          prdata = '0;
		endcase
	end

	// rotation and projection
	vrp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.vertex (vertex),
		.full   (full),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// decoupling queue
	vrp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	// division and screen mapping
	vrp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

`default_nettype wire

/* rtl/vrp_front.sv */
`default_nettype none

module vrp_front import vrp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire logic    push,
	input  wire vertex_t vertex,
	output logic         full,
	input  wire logic    q_full,
	output logic         q_push,
	output proj_t        q_data
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [31:0] xcz_s1, ysz_s1, xsz_s1, ycz_s1;
	logic signed [15:0] z_s1;

	logic signed [32:0] xsum, ysum;
	logic signed [18:0] xr_s2, yr_s2;
	logic signed [15:0] z_s2;

	logic signed [34:0] ycx_s3, zsx_s3, ysx_s3, zcx_s3;
	logic signed [NUM_W-1:0] nx_s3;

	logic signed [35:0] yxsum, zxsum;
	logic signed [21:0] yx_s4;
	logic signed [DIV_W-1:0] w_s4;
	logic signed [NUM_W-1:0] nx_s4;

	logic signed [NUM_W-1:0] nx_s5, ny_s5, nz_s5;
	logic signed [DIV_W-1:0] w_s5;

	// the front moves unless its last item cannot enter the queue
	assign en     = !v_s5 || !q_full;
	assign full   = !en;
	assign q_push = v_s5 && !q_full;
	assign q_data = '{nx: nx_s5, ny: ny_s5, nz: nz_s5, w: w_s5};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// z rotation sums, rounded to q.12
	always_comb begin
		xsum = 33'(xcz_s1) - 33'(ysz_s1);
		ysum = 33'(xsz_s1) + 33'(ycz_s1);
	end

	// x rotation sums, rounded to q.12
	always_comb begin
		yxsum = 36'(ycx_s3) - 36'(zsx_s3);
		zxsum = 36'(ysx_s3) + 36'(zcx_s3);
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// z rotation products
			xcz_s1 <= $signed(vertex.vertex_x) * $signed(cfg.cos_z_rot);
			ysz_s1 <= $signed(vertex.vertex_y) * $signed(cfg.sin_z_rot);
			xsz_s1 <= $signed(vertex.vertex_x) * $signed(cfg.sin_z_rot);
			ycz_s1 <= $signed(vertex.vertex_y) * $signed(cfg.cos_z_rot);
			z_s1   <= vertex.vertex_z;

			xr_s2 <= 19'((xsum + 33'sd8192) >>> 14);
			yr_s2 <= 19'((ysum + 33'sd8192) >>> 14);
			z_s2  <= z_s1;

			// x rotation products and x projection
			ycx_s3 <= 35'(yr_s2) * 35'($signed(cfg.cos_x_rot));
			zsx_s3 <= 35'(z_s2) * 35'($signed(cfg.sin_x_rot));
			ysx_s3 <= 35'(yr_s2) * 35'($signed(cfg.sin_x_rot));
			zcx_s3 <= 35'(z_s2) * 35'($signed(cfg.cos_x_rot));
			nx_s3  <= NUM_W'(xr_s2) * NUM_W'($signed({1'b0, cfg.proj_x_scale}));

			// push into the screen by 3.0
			yx_s4 <= 22'((yxsum + 36'sd8192) >>> 14);
			w_s4  <= DIV_W'((zxsum + 36'sd8192) >>> 14) + DIV_W'(12288);
			nx_s4 <= nx_s3;

			// y and depth projection
			nx_s5 <= nx_s4;
			ny_s5 <= NUM_W'(yx_s4) * NUM_W'($signed({1'b0, cfg.proj_y_scale}));
			nz_s5 <= NUM_W'(w_s4) * NUM_W'($signed({1'b0, cfg.depth_scale}))
				+ (NUM_W'($signed(cfg.depth_offset)) <<< 12);
			w_s5  <= w_s4;
		end
	end

	property p_hold_on_stall;
		@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5});
	endproperty
	a_hold_on_stall: assert property (p_hold_on_stall)
		else $error("front moved while stalled");

endmodule

`default_nettype wire

/* rtl/vrp_queue.sv */
`default_nettype none

module vrp_queue import vrp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire proj_t wdata,
	output logic       full,
	input  wire logic  pop,
	output proj_t      rdata,
	output logic       valid
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	proj_t            mem_q [DEPTH];
	logic [PTR_W-1:0] head_q, tail_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W + 1)'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[head_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= wdata;
		end
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W + 1)'(DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("queue overfilled");

	property p_pop_needs_item;
		@(posedge clk) disable iff (!arst_n)
		pop |-> valid;
	endproperty
	a_pop_needs_item: assert property (p_pop_needs_item)
		else $error("queue popped while empty");

endmodule

`default_nettype wire

/* rtl/vrp_back.sv */
`default_nettype none

module vrp_back import vrp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire proj_t q_data,
	output logic       q_pop,
	input  wire logic  pop,
	output logic       empty,
	output result_t    result
);

	typedef struct packed {
		logic [LANES-1:0][NUM_W-1:0] nq;
		logic [LANES-1:0][DIV_W-1:0] rem;
		logic [DIV_W-1:0]            d;
		logic [LANES-1:0]            neg;
		logic                        wz;
		logic [LANES-1:0][RND_W-1:0] rnd;
	} div_t;

	// one restoring step on every lane
	function automatic div_t div_step(input div_t s);
		div_t         o;
		logic [DIV_W:0] r_ext;
		o = s;
		for (int i = 0; i < LANES; i++) begin
			r_ext = {s.rem[i], s.nq[i][NUM_W-1]};
			if (r_ext >= {1'b0, s.d}) begin
				o.rem[i] = DIV_W'(r_ext - {1'b0, s.d});
				o.nq[i]  = {s.nq[i][NUM_W-2:0], 1'b1};
			end else begin
				o.rem[i] = r_ext[DIV_W-1:0];
				o.nq[i]  = {s.nq[i][NUM_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	logic en;
	logic [NUM_W:0] dv_s;
	div_t           div_s [NUM_W+1];
	div_t           prep;
	logic           fix_vld_q, map_vld_q, out_vld_q;

	logic signed [NUM_W-1:0] num [LANES];
	logic signed [NUM_W:0]   val [LANES];
	logic signed [CLAMP_W-1:0] vx_q, vy_q;
	logic signed [OUT_W-1:0] dep_q, dep2_q;
	logic wz_q, wz2_q;
	logic signed [PROD_W-1:0] px_q, py_q;
	result_t res_q;

	assign en     = !out_vld_q || pop;
	assign q_pop  = en && q_valid;
	assign empty  = !out_vld_q;
	assign result = res_q;

	// sign handling and the rounded fallback for zero w
	always_comb begin
		num[0] = q_data.nx;
		num[1] = q_data.ny;
		num[2] = q_data.nz;
		prep.wz  = (q_data.w == '0);
		prep.d   = q_data.w[DIV_W-1] ? DIV_W'(-q_data.w) : DIV_W'(q_data.w);
		for (int i = 0; i < LANES; i++) begin
			prep.nq[i]  = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
			prep.rem[i] = '0;
			prep.neg[i] = num[i][NUM_W-1] ^ q_data.w[DIV_W-1];
			prep.rnd[i] = RND_W'((num[i] + NUM_W'(2048)) >>> 12);
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s      <= '0;
			fix_vld_q <= 1'b0;
			map_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			dv_s      <= {dv_s[NUM_W-1:0], q_valid};
			fix_vld_q <= dv_s[NUM_W];
			map_vld_q <= fix_vld_q;
			out_vld_q <= map_vld_q;
		end
	end

	// divider entry
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= prep;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= div_step(div_s[k]);
			end
		end
	end

	// apply sign or take the rounded value
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (div_s[NUM_W].wz) begin
				val[i] = (NUM_W + 1)'($signed(div_s[NUM_W].rnd[i]));
			end else if (div_s[NUM_W].neg[i]) begin
				val[i] = -$signed({1'b0, div_s[NUM_W].nq[i]});
			end else begin
				val[i] = $signed({1'b0, div_s[NUM_W].nq[i]});
			end
		end
	end

	// clamp, map to pixels, saturate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				if (val[i] > (NUM_W + 1)'(1 <<< 29)) begin
					if (i == 0) vx_q <= CLAMP_W'(1 <<< 29);
					else        vy_q <= CLAMP_W'(1 <<< 29);
				end else if (val[i] < -(NUM_W + 1)'(1 <<< 29)) begin
					if (i == 0) vx_q <= -CLAMP_W'(1 <<< 29);
					else        vy_q <= -CLAMP_W'(1 <<< 29);
				end else begin
					if (i == 0) vx_q <= CLAMP_W'(val[i]);
					else        vy_q <= CLAMP_W'(val[i]);
				end
			end
			dep_q <= sat_out(PROD_W'(val[2]));
			wz_q  <= div_s[NUM_W].wz;

			px_q <= (PROD_W'(vx_q) + PROD_W'(4096))
				* PROD_W'($signed({1'b0, SIZE_W'(SCREEN_WIDTH)})) + PROD_W'(16);
			py_q <= (PROD_W'(vy_q) + PROD_W'(4096))
				* PROD_W'($signed({1'b0, SIZE_W'(SCREEN_HEIGHT)})) + PROD_W'(16);
			dep2_q <= dep_q;
			wz2_q  <= wz_q;

			res_q.screen_x <= sat_out(px_q >>> 5);
			res_q.screen_y <= sat_out(py_q >>> 5);
			res_q.depth    <= dep2_q;
			res_q.w_zero   <= wz2_q;
		end
	end

	property p_hold_on_stall;
		@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({dv_s, fix_vld_q, map_vld_q});
	endproperty
	a_hold_on_stall: assert property (p_hold_on_stall)
		else $error("divider moved while stalled");

endmodule

`default_nettype wire
